FILE: hw/rtl/hpq_pkg.sv
// Shared types, sizes and operation codes of the min-heap priority queue.
package hpq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_W     = 64;
  localparam int CNT_OUT_W = 11;
  // Heap positions are counted from 1, so position CAPACITY sits on level LEVELS-1.
  localparam int LEVELS    = $clog2(CAPACITY + 1);
  localparam int POS_W     = LEVELS;
  localparam int IDX_W     = LEVELS - 1;
  localparam int LVL_W     = $clog2(LEVELS);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [LVL_W-1:0]        lvl_t;
  typedef logic [1:0]              op_t;

  localparam op_t OP_INS   = 2'd0;
  localparam op_t OP_SIFT  = 2'd1;
  localparam op_t OP_FETCH = 2'd2;

  localparam key_t EMPTY_KEY = key_t'(127);

  // Command from the sequencer to the level that matches its level field.
  typedef struct packed {
    logic valid;
    op_t  op;
    lvl_t level;
    idx_t idx;
    key_t key;
  } cell_cmd_t;

  // Work handed from one level to the next one down.
  typedef struct packed {
    logic valid;
    op_t  op;
    idx_t idx;
    key_t key;
  } cell_tok_t;

  // Write request sent from a level to the level above it.
  typedef struct packed {
    logic valid;
    idx_t idx;
    key_t key;
  } cell_wb_t;

  // Values shared by every level during one transaction.
  typedef struct packed {
    pos_t ins_pos;
    lvl_t ins_lvl;
    pos_t count;
  } heap_ctx_t;

  // Status a level reports back to the sequencer.
  typedef struct packed {
    logic done;
    logic ret_valid;
    key_t ret_key;
  } cell_stat_t;

  // Level of a heap position: the index of its highest set bit.
  function automatic lvl_t msb_level(input pos_t p);
    lvl_t r;
    r = '0;
    for (int b = 0; b < POS_W; b++) begin
      if (p[b]) begin
        r = lvl_t'(b);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/hpq_ram.sv
// Generic single-port RAM with registered read data.
module hpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic                                    re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  logic [WIDTH-1:0]                        wdata,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/hpq_cell.sv
// One heap level: walks an insert or a sift-down, or serves a fetch, through the level's own RAM.
module hpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  hpq_pkg::lvl_t      level_id,
  input  hpq_pkg::cell_cmd_t cmd,
  input  hpq_pkg::heap_ctx_t ctx,
  input  hpq_pkg::cell_tok_t tok_in,
  input  hpq_pkg::cell_wb_t  wb_in,
  output hpq_pkg::cell_tok_t tok_out,
  output hpq_pkg::cell_wb_t  wb_out,
  output hpq_pkg::cell_stat_t stat,
  output logic               ram_we,
  output logic               ram_re,
  output hpq_pkg::idx_t      ram_addr,
  output hpq_pkg::key_t      ram_wdata,
  input  hpq_pkg::key_t      ram_rdata
);
  import hpq_pkg::*;

  localparam logic [2:0] C_IDLE      = 3'd0;
  localparam logic [2:0] C_INS_CMP   = 3'd1;
  localparam logic [2:0] C_SIFT_RD1  = 3'd2;
  localparam logic [2:0] C_SIFT_CMP  = 3'd3;
  localparam logic [2:0] C_FETCH_RET = 3'd4;

  logic [2:0] state, state_next;
  key_t       key, key_next;
  idx_t       idx, idx_next;
  key_t       v0, v0_next;
  logic       lt0, lt0_next;
  logic       c1_ok, c1_ok_next;

  cell_tok_t tin;
  pos_t      base;
  pos_t      p0;
  idx_t      c0;
  logic      c0_ok;
  logic      c1_ok_now;
  lvl_t      bsel;
  logic      pick1;
  logic      move;

  always_comb begin
    tin = tok_in;
    if (!tok_in.valid && cmd.valid && (cmd.level == level_id)) begin
      tin.valid = 1'b1;
      tin.op    = cmd.op;
      tin.idx   = cmd.idx;
      tin.key   = cmd.key;
    end

    // Children of the parent slot named by the incoming token live in this level.
    base      = pos_t'(1) << level_id;
    c0        = idx_t'({tin.idx, 1'b0});
    p0        = base | pos_t'(c0);
    c0_ok     = (p0 <= ctx.count);
    c1_ok_now = ((p0 | pos_t'(1)) <= ctx.count);

    bsel  = ctx.ins_lvl - level_id - lvl_t'(1);
    pick1 = c1_ok && ($signed(ram_rdata) < $signed(v0));
    move  = pick1 ? ($signed(ram_rdata) < $signed(key)) : lt0;

    state_next = state;
    key_next   = key;
    idx_next   = idx;
    v0_next    = v0;
    lt0_next   = lt0;
    c1_ok_next = c1_ok;
    tok_out    = '0;
    wb_out     = '0;
    stat       = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = idx;
    ram_wdata  = key;

    case (state)
      C_IDLE: begin
        if (tin.valid) begin
          case (tin.op)
            OP_INS: begin
              if (level_id == ctx.ins_lvl) begin
                ram_we    = 1'b1;
                ram_addr  = tin.idx;
                ram_wdata = tin.key;
                stat.done = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_addr   = tin.idx;
                key_next   = tin.key;
                idx_next   = tin.idx;
                state_next = C_INS_CMP;
              end
            end
            OP_FETCH: begin
              ram_re     = 1'b1;
              ram_addr   = tin.idx;
              state_next = C_FETCH_RET;
            end
            OP_SIFT: begin
              key_next   = tin.key;
              idx_next   = tin.idx;
              c1_ok_next = c1_ok_now;
              if (!c0_ok) begin
                wb_out.valid = 1'b1;
                wb_out.idx   = tin.idx;
                wb_out.key   = tin.key;
                stat.done    = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_addr   = c0;
                state_next = C_SIFT_RD1;
              end
            end
            default: ;
          endcase
        end
      end
      C_INS_CMP: begin
        tok_out.valid = 1'b1;
        tok_out.op    = OP_INS;
        tok_out.idx   = idx_t'({idx, ctx.ins_pos[bsel]});
        if ($signed(key) < $signed(ram_rdata)) begin
          ram_we      = 1'b1;
          ram_addr    = idx;
          ram_wdata   = key;
          tok_out.key = ram_rdata;
        end else begin
          tok_out.key = key;
        end
        state_next = C_IDLE;
      end
      C_SIFT_RD1: begin
        v0_next  = ram_rdata;
        lt0_next = ($signed(ram_rdata) < $signed(key));
        if (c1_ok) begin
          ram_re   = 1'b1;
          ram_addr = idx_t'({idx, 1'b1});
        end
        state_next = C_SIFT_CMP;
      end
      C_SIFT_CMP: begin
        wb_out.valid = 1'b1;
        wb_out.idx   = idx;
        if (move) begin
          wb_out.key    = pick1 ? ram_rdata : v0;
          tok_out.valid = 1'b1;
          tok_out.op    = OP_SIFT;
          tok_out.idx   = idx_t'({idx, pick1});
          tok_out.key   = key;
        end else begin
          wb_out.key = key;
          stat.done  = 1'b1;
        end
        state_next = C_IDLE;
      end
      C_FETCH_RET: begin
        stat.ret_valid = 1'b1;
        stat.ret_key   = ram_rdata;
        state_next     = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase

    // The level below is to write here only while this level is idle; no check is made.
    if (wb_in.valid) begin
      ram_we    = 1'b1;
      ram_re    = 1'b0;
      ram_addr  = wb_in.idx;
      ram_wdata = wb_in.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    idx   <= idx_next;
    v0    <= v0_next;
    lt0   <= lt0_next;
    c1_ok <= c1_ok_next;
  end

endmodule

FILE: hw/rtl/min_heap_priority_queue_core.sv
// Top level of the min-heap priority queue: sequencer, level cells and level RAMs.
//
// A binary min-heap of up to CAPACITY signed 64-bit keys. Each input transaction is an
// insert (kind 0) or an extract of the minimum (kind 1), and each produces exactly one
// output transaction carrying the extracted key (127 with was_empty set when the heap
// is empty, zero for inserts), a was_full flag for an insert dropped at capacity, and
// the entry count after the operation. The heap is stored one level per cell: cell L
// owns a single-port RAM with the slots of level L (2^L, but on the last level only as
// many as CAPACITY reaches), so every heap access goes to a different level in turn and
// work is passed from a cell to the one below it. One transaction is processed at a
// time. An insert walks top-down from the root to the new slot, and each level's compare
// overlaps the read of the level below. An extract reads the root and the last entry,
// then sifts the last entry down with two child reads per level on the single RAM port,
// the compare and write-back overlapping the next level's first read. A finished result
// sits in an output register, and the next input transaction is accepted while it waits
// to be taken. The heap RAM is not cleared at reset; only positions up to the entry
// count are ever read.
module min_heap_priority_queue_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic signed [hpq_pkg::KEY_W-1:0]   key_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [hpq_pkg::KEY_W-1:0]   key_out,
  output logic                               was_empty,
  output logic                               was_full,
  output logic [hpq_pkg::CNT_OUT_W-1:0]      entry_count
);
  import hpq_pkg::*;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_INS  = 3'd1;
  localparam logic [2:0] T_ROOT = 3'd2;
  localparam logic [2:0] T_LAST = 3'd3;
  localparam logic [2:0] T_SIFT = 3'd4;
  localparam logic [2:0] T_RES  = 3'd5;

  logic [2:0] state;
  pos_t       count;
  pos_t       op_pos;
  lvl_t       op_lvl;
  cell_cmd_t  cmd;
  key_t       res_key;
  logic       res_empty;
  logic       res_full;

  heap_ctx_t  ctx;
  cell_tok_t  tok [LEVELS+1];
  cell_wb_t   wb_up [LEVELS];
  cell_wb_t   wb_dn [LEVELS];
  cell_wb_t   term_wb;
  cell_stat_t stat [LEVELS];

  logic       done_any;
  logic       ret_valid_any;
  key_t       ret_key_any;
  pos_t       ins_pos;
  lvl_t       last_lvl;

  assign ctx.ins_pos = op_pos;
  assign ctx.ins_lvl = op_lvl;
  assign ctx.count   = count;

  assign tok[0] = '0;

  // A sift that leaves the deepest level has no children to look at, so the carried
  // key simply drops into the slot that the last cell just vacated.
  assign term_wb.valid = tok[LEVELS].valid;
  assign term_wb.idx   = tok[LEVELS].idx;
  assign term_wb.key   = tok[LEVELS].key;

  for (genvar L = 0; L < LEVELS; L++) begin : g_level
    localparam int LVL_SIZE = 1 << L;
    localparam int TAIL     = CAPACITY + 1 - LVL_SIZE;
    localparam int RDEPTH   = (LVL_SIZE < TAIL) ? LVL_SIZE : TAIL;
    localparam int RAW      = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;

    logic ram_we;
    logic ram_re;
    idx_t ram_addr;
    key_t ram_wdata;
    key_t ram_rdata;

    hpq_ram #(
      .WIDTH (KEY_W),
      .DEPTH (RDEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr[RAW-1:0]),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
    );

    if (L == LEVELS - 1) begin : g_wb_last
      assign wb_dn[L] = term_wb;
    end else begin : g_wb_mid
      assign wb_dn[L] = wb_up[L+1];
    end

    if (L == 0) begin : g_root
      hpq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .level_id  (lvl_t'(L)),
        .cmd       (cmd),
        .ctx       (ctx),
        .tok_in    (tok[L]),
        .wb_in     (wb_dn[L]),
        .tok_out   (tok[L+1]),
        .wb_out    (),
        .stat      (stat[L]),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
      );
      assign wb_up[L] = '0;
    end else begin : g_inner
      hpq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .level_id  (lvl_t'(L)),
        .cmd       (cmd),
        .ctx       (ctx),
        .tok_in    (tok[L]),
        .wb_in     (wb_dn[L]),
        .tok_out   (tok[L+1]),
        .wb_out    (wb_up[L]),
        .stat      (stat[L]),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
      );
    end
  end

  // Only one cell reports status at a time, so the status lines can simply be merged.
  always_comb begin
    done_any      = term_wb.valid;
    ret_valid_any = 1'b0;
    ret_key_any   = '0;
    for (int l = 0; l < LEVELS; l++) begin
      done_any      = done_any | stat[l].done;
      ret_valid_any = ret_valid_any | stat[l].ret_valid;
      ret_key_any   = ret_key_any | stat[l].ret_key;
    end
  end

  assign ins_pos  = count + pos_t'(1);
  assign last_lvl = msb_level(count);

  assign in_stall = (state != T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      count     <= '0;
      cmd       <= '0;
      out_valid <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result replaces it.
      if (out_valid && !out_stall && (state != T_RES)) begin
        out_valid <= 1'b0;
      end

      case (state)
        T_IDLE: begin
          if (in_valid) begin
            if (!kind) begin
              res_key   <= '0;
              res_empty <= 1'b0;
              if (count == pos_t'(CAPACITY)) begin
                res_full <= 1'b1;
                state    <= T_RES;
              end else begin
                // The new key enters at the root and is carried down the path
                // toward the first free slot.
                res_full  <= 1'b0;
                count     <= ins_pos;
                op_pos    <= ins_pos;
                op_lvl    <= msb_level(ins_pos);
                cmd.valid <= 1'b1;
                cmd.op    <= OP_INS;
                cmd.level <= '0;
                cmd.idx   <= '0;
                cmd.key   <= key_in;
                state     <= T_INS;
              end
            end else begin
              res_full <= 1'b0;
              if (count == '0) begin
                res_key   <= EMPTY_KEY;
                res_empty <= 1'b1;
                state     <= T_RES;
              end else begin
                res_key   <= '0;
                res_empty <= 1'b0;
                cmd.valid <= 1'b1;
                cmd.op    <= OP_FETCH;
                cmd.level <= '0;
                cmd.idx   <= '0;
                state     <= T_ROOT;
              end
            end
          end
        end
        T_INS: begin
          cmd.valid <= 1'b0;
          if (done_any) begin
            state <= T_RES;
          end
        end
        T_ROOT: begin
          if (ret_valid_any) begin
            res_key <= ret_key_any;
            if (count == pos_t'(1)) begin
              cmd.valid <= 1'b0;
              count     <= '0;
              state     <= T_RES;
            end else begin
              // Fetch the last entry, which will refill the root.
              cmd.valid <= 1'b1;
              cmd.op    <= OP_FETCH;
              cmd.level <= last_lvl;
              cmd.idx   <= idx_t'(count ^ (pos_t'(1) << last_lvl));
              state     <= T_LAST;
            end
          end else begin
            cmd.valid <= 1'b0;
          end
        end
        T_LAST: begin
          if (ret_valid_any) begin
            // The root is now a hole; level 1 compares the root's children
            // with the carried key.
            count     <= count - pos_t'(1);
            cmd.valid <= 1'b1;
            cmd.op    <= OP_SIFT;
            cmd.level <= lvl_t'(1);
            cmd.idx   <= '0;
            cmd.key   <= ret_key_any;
            state     <= T_SIFT;
          end else begin
            cmd.valid <= 1'b0;
          end
        end
        T_SIFT: begin
          cmd.valid <= 1'b0;
          if (done_any) begin
            state <= T_RES;
          end
        end
        T_RES: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            key_out     <= res_key;
            was_empty   <= res_empty;
            was_full    <= res_full;
            entry_count <= CNT_OUT_W'(count);
            state       <= T_IDLE;
          end
        end
        default: begin
          cmd.valid <= 1'b0;
          state     <= T_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: test/min_heap_priority_queue_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the min-heap priority queue core, with its own heap predictor.
module min_heap_priority_queue_core_tb;

  import hpq_pkg::*;

  // Operation codes carried on the kind port.
  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam key_t KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam key_t KEY_MIN = 64'sh8000_0000_0000_0000;

  // Cycles allowed for the last result to drain, and quiet cycles after it.
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 100;
  // Length of the long receiver hold-off that backs the queue up into its input.
  localparam int HOLD_CYCLES = 400;
  // Room for expected results; the block never owes more than a few.
  localparam int EXP_DEPTH = 16;

  // One result transaction as the block reports it.
  typedef struct packed {
    key_t                 key;
    logic                 empty;
    logic                 full;
    logic [CNT_OUT_W-1:0] count;
  } heap_res_t;

  // One row of the directed script. Rows with typed set carry a hand-written
  // result; all other rows are checked against the predictor.
  typedef struct {
    logic      op;
    key_t      key;
    bit        typed;
    heap_res_t res;
  } script_row_t;

  localparam int SCRIPT_LEN = 22;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = KIND_INSERT;
  key_t                 key_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  key_t                 key_out;
  logic                 was_empty;
  logic                 was_full;
  logic [CNT_OUT_W-1:0] entry_count;

  // Predictor state: a plain array heap and its fill level.
  key_t      heap_keys [CAPACITY];
  int        heap_size = 0;

  // Results still owed by the block, oldest first, in a ring with two counters.
  heap_res_t expected [EXP_DEPTH];
  int        exp_wr = 0;
  int        exp_rd = 0;
  heap_res_t next_result;
  int        fail_count = 0;

  // Traffic shaping, set by the main sequence for each phase.
  int        sender_idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_go = 1'b0;
  bit        hold_used = 1'b0;
  int        hold_left = 0;

  script_row_t script [SCRIPT_LEN];

  min_heap_priority_queue_core DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key_in      (key_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .key_out     (key_out),
    .was_empty   (was_empty),
    .was_full    (was_full),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Applies one operation to the predicted heap and returns the result the block
  // must report. Insert sifts up while the parent is strictly greater; extract
  // moves the last key to the root and sifts down toward the smaller child, with
  // the left child winning a tie.
  function automatic heap_res_t heap_apply(input logic op, input key_t key);
    heap_res_t r;
    int        pos;
    int        up;
    int        lc;
    int        rc;
    int        best;
    bit        settled;
    key_t      t;
    r = '0;
    if (op == KIND_INSERT) begin
      if (heap_size >= CAPACITY) begin
        r.full = 1'b1;
      end else begin
        pos = heap_size;
        heap_keys[pos] = key;
        heap_size++;
        settled = 1'b0;
        while (pos != 0 && !settled) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] <= heap_keys[pos]) begin
            settled = 1'b1;
          end else begin
            t = heap_keys[up];
            heap_keys[up] = heap_keys[pos];
            heap_keys[pos] = t;
            pos = up;
          end
        end
      end
    end else if (heap_size == 0) begin
      r.key   = EMPTY_KEY;
      r.empty = 1'b1;
    end else begin
      r.key = heap_keys[0];
      heap_size--;
      if (heap_size > 0) begin
        heap_keys[0] = heap_keys[heap_size];
        pos = 0;
        settled = 1'b0;
        while (!settled) begin
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          best = pos;
          if (lc < heap_size && heap_keys[lc] < heap_keys[best]) begin
            best = lc;
          end
          if (rc < heap_size && heap_keys[rc] < heap_keys[best]) begin
            best = rc;
          end
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            t = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = t;
            pos = best;
          end
        end
      end
    end
    r.count = CNT_OUT_W'(heap_size);
    return r;
  endfunction

  // Keys mix the extremes, a narrow band around zero that produces many
  // duplicates, and fully random 64-bit values so that every key bit toggles.
  function automatic key_t rand_key();
    case ($urandom_range(0, 7))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2, 3: return key_t'($urandom_range(0, 64)) - key_t'(32);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one input transaction and holds it until the block accepts it. The
  // expected result is computed at the accepting edge, so the predictor always
  // sees operations in the order the block does. The sender may first sit idle
  // for a random number of cycles with valid low.
  task automatic send_op(input logic op, input key_t key, input bit typed = 1'b0,
                         input heap_res_t typed_res = '0);
    heap_res_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= op;
    key_in   <= key;
    do @(posedge clk); while (in_stall);
    predicted = heap_apply(op, key);
    expected[exp_wr % EXP_DEPTH] = typed ? typed_res : predicted;
    exp_wr++;
  endtask

  // Random operations, inserting with the given probability in percent.
  task automatic run_mix(input int n, input int ins_pct);
    for (int i = 0; i < n; i++) begin
      send_op(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_EXTRACT, rand_key());
    end
  endtask

  // Receiver side. Normally it stalls at random with the phase's rate; once the
  // main sequence raises hold_go it stalls solidly through a hold-off counted here,
  // so the block fills its output register and then stalls its input.
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      out_stall <= 1'b1;
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: every accepted result transaction is matched, field by
  // field, against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_rd == exp_wr) begin
        $error("unexpected result transaction: key_out %0d, entry_count %0d",
               key_out, entry_count);
        fail_count++;
      end else begin
        next_result = expected[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (key_out !== next_result.key) begin
          $error("key_out: expected %0d, actual %0d", next_result.key, key_out);
          fail_count++;
        end
        if (was_empty !== next_result.empty) begin
          $error("was_empty: expected %0d, actual %0d", next_result.empty, was_empty);
          fail_count++;
        end
        if (was_full !== next_result.full) begin
          $error("was_full: expected %0d, actual %0d", next_result.full, was_full);
          fail_count++;
        end
        if (entry_count !== next_result.count) begin
          $error("entry_count: expected %0d, actual %0d", next_result.count, entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int waited;
    bit lost;

    // Directed script. The first rows walk the extremes from an empty heap, where
    // the answers are obvious; the middle rows build duplicates and near-extreme
    // keys; the run then drains the heap and ends with another empty extract.
    script[0]  = '{KIND_EXTRACT, '0,      1'b1, '{EMPTY_KEY, 1'b1, 1'b0, 11'd0}};
    script[1]  = '{KIND_INSERT,  KEY_MAX, 1'b1, '{'0, 1'b0, 1'b0, 11'd1}};
    script[2]  = '{KIND_INSERT,  KEY_MIN, 1'b1, '{'0, 1'b0, 1'b0, 11'd2}};
    script[3]  = '{KIND_INSERT,  '0,      1'b1, '{'0, 1'b0, 1'b0, 11'd3}};
    script[4]  = '{KIND_INSERT,  -64'sd1, 1'b1, '{'0, 1'b0, 1'b0, 11'd4}};
    script[5]  = '{KIND_INSERT,  EMPTY_KEY, 1'b1, '{'0, 1'b0, 1'b0, 11'd5}};
    script[6]  = '{KIND_EXTRACT, '0,      1'b1, '{KEY_MIN, 1'b0, 1'b0, 11'd4}};
    script[7]  = '{KIND_EXTRACT, '0,      1'b1, '{-64'sd1, 1'b0, 1'b0, 11'd3}};
    script[8]  = '{KIND_INSERT,  64'sd5,  1'b0, '0};
    script[9]  = '{KIND_INSERT,  64'sd5,  1'b0, '0};
    script[10] = '{KIND_INSERT,  64'sd3,  1'b0, '0};
    script[11] = '{KIND_INSERT,  -64'sd2, 1'b0, '0};
    script[12] = '{KIND_INSERT,  KEY_MIN + 64'sd1, 1'b0, '0};
    for (int i = 13; i < SCRIPT_LEN - 1; i++) begin
      script[i] = '{KIND_EXTRACT, '0, 1'b0, '0};
    end
    script[SCRIPT_LEN-1] = '{KIND_EXTRACT, '0, 1'b1, '{EMPTY_KEY, 1'b1, 1'b0, 11'd0}};

    lost = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with no idling on either side.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_op(script[i].op, script[i].key, script[i].typed, script[i].res);
    end

    // Random mix, no idling at all.
    run_mix(30, 60);

    // Random mix with the sender idle about half the time.
    sender_idle_pct = 50;
    run_mix(30, 60);

    // Fill to capacity with the receiver stalling half the time. The long
    // hold-off at the start backs the block up while the sender keeps offering.
    sender_idle_pct = 0;
    stall_pct       = 50;
    hold_go         <= 1'b1;
    while (heap_size < CAPACITY) begin
      send_op(($urandom_range(0, 99) < 97) ? KIND_INSERT : KIND_EXTRACT, rand_key());
    end
    // At capacity: inserts are dropped, an extract frees exactly one slot.
    repeat (10) send_op(KIND_INSERT, rand_key());
    repeat (4) begin
      send_op(KIND_EXTRACT, '0);
      send_op(KIND_INSERT, rand_key());
      send_op(KIND_INSERT, rand_key());
    end

    // Extract-heavy mix from a full heap with both sides idling about a third
    // of the time.
    sender_idle_pct = 32;
    stall_pct       = 32;
    run_mix(40, 30);
    in_valid <= 1'b0;

    // Let the last results come out, then watch for anything extra.
    waited = 0;
    while (exp_rd != exp_wr && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (exp_rd != exp_wr) begin
      $error("%0d expected result transactions never arrived", exp_wr - exp_rd);
      lost = 1'b1;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && !lost) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/hpq_pkg.sv
hw/rtl/hpq_ram.sv
hw/rtl/hpq_cell.sv
hw/rtl/min_heap_priority_queue_core.sv
test/min_heap_priority_queue_core_tb.sv
